>>> rtl/wes_pkg.sv
// wes_pkg: types, constants and helpers shared by the wave elevation blocks
// depends on nothing
package wes_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [33:0] TWO_PI_Q28 = 34'sd1686629713;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic REG_COUNT = 1'b0;

    // one request as it waits in the queue
    typedef struct packed {
        logic        cmd;
        logic [5:0]  entry_index;
        logic [15:0] amplitude;
        logic [31:0] wavenumber_x;
        logic [31:0] wavenumber_y;
        logic [31:0] angular_rate;
        logic [15:0] phase_offset;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] query_time;
        logic [6:0]  term_limit;
    } item_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    typedef enum logic [4:0] {
        BK_IDLE, BK_READ, BK_KX, BK_KY, BK_RT, BK_SUB, BK_ANGLE, BK_ROT, BK_QUAD,
        BK_AC, BK_AS, BK_PS, BK_PX, BK_TX, BK_SX, BK_TY, BK_SY, BK_DONE
    } bk_state_t;

    // arctangent of 2^-k in turns, 2^32 per turn
    function automatic logic signed [33:0] atan_turns(input logic [4:0] k);
        logic signed [33:0] r;
        case (k)
            5'd0:  r = 34'sd536870912;
            5'd1:  r = 34'sd316933406;
            5'd2:  r = 34'sd167458907;
            5'd3:  r = 34'sd85004756;
            5'd4:  r = 34'sd42667331;
            5'd5:  r = 34'sd21354465;
            5'd6:  r = 34'sd10679838;
            5'd7:  r = 34'sd5340245;
            5'd8:  r = 34'sd2670163;
            5'd9:  r = 34'sd1335087;
            5'd10: r = 34'sd667544;
            5'd11: r = 34'sd333772;
            5'd12: r = 34'sd166886;
            5'd13: r = 34'sd83443;
            5'd14: r = 34'sd41722;
            5'd15: r = 34'sd20861;
            5'd16: r = 34'sd10430;
            5'd17: r = 34'sd5215;
            5'd18: r = 34'sd2608;
            5'd19: r = 34'sd1304;
            5'd20: r = 34'sd652;
            5'd21: r = 34'sd326;
            5'd22: r = 34'sd163;
            5'd23: r = 34'sd81;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

    // saturate a 64-bit signed value to 32 bits
    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sh7FFF_FFFF)
            r = 32'h7FFF_FFFF;
        else if (v < -64'sh8000_0000)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

>>> rtl/wave_elevation_superposition.sv
// wave_elevation_superposition: top level, register port, request queue and evaluator
// depends on wes_pkg, wes_front, wes_back
//
// usage
//   a request is taken when start is high and busy is low. cmd 0 loads one
//   table entry (entry_index, amplitude, wavenumbers, rate, phase); cmd 1
//   evaluates the wave field at (pos_x, pos_y, query_time) over term_limit
//   leading entries, 0 meaning all entries in use.
//   component_count is written over the apb port at address 0.
//   requests wait in a two-entry queue; busy is high while the queue is full.
//   a load is done by the evaluator and gives no result.
//   an evaluation walks the shared multiplier, for each term, through its angle
//   products, 24 cordic steps and the accumulate products before the done
//   strobe. a zero-term evaluation goes straight to the done state.
//   each result shows on elevation, slope_x, slope_y for one cycle while done
//   is high; the receiver cannot hold it off.
//   reset clears the queue, the sequencer and component_count; the table
//   contents are undefined until loaded.
module wave_elevation_superposition #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [5:0]  entry_index,
    input  logic [15:0] amplitude,
    input  logic [31:0] wavenumber_x,
    input  logic [31:0] wavenumber_y,
    input  logic [31:0] angular_rate,
    input  logic [15:0] phase_offset,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] query_time,
    input  logic [6:0]  term_limit,
    output logic        done,
    output logic [31:0] elevation,
    output logic [31:0] slope_x,
    output logic [31:0] slope_y,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import wes_pkg::*;

    logic [6:0] count_reg;
    item_t      item;
    head_t      head;
    logic       pop;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_COUNT) ? {25'd0, count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 7'd0;
        else if (psel && penable && pwrite && pready && paddr[2] == REG_COUNT)
            count_reg <= pwdata[6:0];
    end

    // request fields
    assign item = '{cmd, entry_index, amplitude, wavenumber_x, wavenumber_y,
                    angular_rate, phase_offset, pos_x, pos_y, query_time, term_limit};

    wes_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .busy  (busy),
        .head  (head),
        .pop   (pop)
    );

    wes_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .pop             (pop),
        .component_count (count_reg),
        .done            (done),
        .elevation       (elevation),
        .slope_x         (slope_x),
        .slope_y         (slope_y)
    );

`ifndef NO_ASSERTIONS
    // done always falls straight after a result strobe
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held for two cycles");
    // the evaluator only takes from a non-empty queue
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head.valid)
        else $error("pop from empty queue");
    // a result follows the done state only
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(u_back.state_reg == BK_DONE))
        else $error("done without finishing an evaluation");
`endif

endmodule

>>> rtl/wes_front.sv
// wes_front: accepts requests and holds them in a two-entry queue
// depends on wes_pkg
module wes_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  wes_pkg::item_t  item,
    output logic            busy,
    output wes_pkg::head_t  head,
    input  logic            pop
);
    import wes_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push, do_pop;

    // queue control
    always_comb
    begin
        busy        = (fill_reg == 2'd2);
        push        = start && !busy;
        do_pop      = pop && (fill_reg != 2'd0);
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, do_pop};
        head.valid  = (fill_reg != 2'd0);
        head.item   = slot_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= item;
    end

endmodule

>>> rtl/wes_back.sv
// wes_back: component table and the shared angle, cordic and multiply-accumulate sequencer
// depends on wes_pkg
module wes_back #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  wes_pkg::head_t  head,
    output logic            pop,
    input  logic [6:0]      component_count,
    output logic            done,
    output logic [31:0]     elevation,
    output logic [31:0]     slope_x,
    output logic [31:0]     slope_y
);
    import wes_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef struct packed {
        logic [15:0] amp;
        logic [31:0] kx;
        logic [31:0] ky;
        logic [31:0] rate;
        logic [15:0] phase;
    } entry_t;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_reg;

    bk_state_t state_reg, state_next;
    logic [CW-1:0] idx_reg, n_reg;
    logic [4:0]  step_reg;
    logic [1:0]  quad_reg;
    logic [31:0] px_reg, py_reg, pt_reg;
    logic signed [63:0] p_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic signed [33:0] c_reg, s_reg, ps_reg;
    logic signed [67:0] prod_reg;
    logic signed [33:0] mul_a, mul_b;
    logic signed [63:0] acc_e_reg, acc_x_reg, acc_y_reg;
    logic        done_reg;
    logic [31:0] elev_reg, sx_reg, sy_reg;

    logic        load_wr, start_eval;
    logic [31:0] angle, ang_bias, resid;
    logic [1:0]  quad;
    int          count_sat, n_int;

    // table write and registered read
    assign load_wr = pop && (head.item.cmd == CMD_LOAD)
                     && (int'(head.item.entry_index) < TABLE_DEPTH);

    always_ff @(posedge clk)
    begin
        if (load_wr)
            mem[AW'(head.item.entry_index)] <= '{head.item.amplitude,
                head.item.wavenumber_x, head.item.wavenumber_y,
                head.item.angular_rate, head.item.phase_offset};
        rd_reg <= mem[idx_reg[AW-1:0]];
    end

    // term count and angle reduction
    always_comb
    begin
        count_sat = (int'(component_count) > TABLE_DEPTH) ? TABLE_DEPTH
                                                          : int'(component_count);
        n_int = (head.item.term_limit == 7'd0 || int'(head.item.term_limit) >= count_sat)
                ? count_sat : int'(head.item.term_limit);
        angle    = p_reg[39:8] + {rd_reg.phase, 16'h0000};
        ang_bias = angle + 32'h2000_0000;
        quad     = ang_bias[31:30];
        resid    = angle - {quad, 30'h0};
    end

    // shared multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            BK_KX:
            begin
                mul_a = 34'($signed(rd_reg.kx));
                mul_b = 34'($signed(px_reg));
            end
            BK_KY:
            begin
                mul_a = 34'($signed(rd_reg.ky));
                mul_b = 34'($signed(py_reg));
            end
            BK_RT:
            begin
                mul_a = {2'b00, rd_reg.rate};
                mul_b = {2'b00, pt_reg};
            end
            BK_AC:
            begin
                mul_a = {18'd0, rd_reg.amp};
                mul_b = c_reg;
            end
            BK_AS:
            begin
                mul_a = {18'd0, rd_reg.amp};
                mul_b = s_reg;
            end
            BK_PX:
            begin
                mul_a = ps_reg;
                mul_b = 34'($signed(rd_reg.kx));
            end
            BK_SX:
            begin
                mul_a = ps_reg;
                mul_b = 34'($signed(rd_reg.ky));
            end
            BK_TX, BK_TY:
            begin
                mul_a = prod_reg[63:30];
                mul_b = TWO_PI_Q28;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        start_eval = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (head.item.cmd == CMD_EVAL)
                    begin
                        start_eval = 1'b1;
                        state_next = (n_int == 0) ? BK_DONE : BK_READ;
                    end
                end
            end
            BK_READ:  state_next = BK_KX;
            BK_KX:    state_next = BK_KY;
            BK_KY:    state_next = BK_RT;
            BK_RT:    state_next = BK_SUB;
            BK_SUB:   state_next = BK_ANGLE;
            BK_ANGLE: state_next = BK_ROT;
            BK_ROT:   state_next = (step_reg == 5'(CORDIC_STEPS - 1)) ? BK_QUAD : BK_ROT;
            BK_QUAD:  state_next = BK_AC;
            BK_AC:    state_next = BK_AS;
            BK_AS:    state_next = BK_PS;
            BK_PS:    state_next = BK_PX;
            BK_PX:    state_next = BK_TX;
            BK_TX:    state_next = BK_SX;
            BK_SX:    state_next = BK_TY;
            BK_TY:    state_next = BK_SY;
            BK_SY:    state_next = (idx_reg + 1'b1 == n_reg) ? BK_DONE : BK_READ;
            BK_DONE:  state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == BK_DONE);
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (start_eval)
        begin
            px_reg    <= head.item.pos_x;
            py_reg    <= head.item.pos_y;
            pt_reg    <= head.item.query_time;
            n_reg     <= CW'(n_int);
            idx_reg   <= '0;
            acc_e_reg <= '0;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end
        case (state_reg)
            BK_KY:  p_reg <= prod_reg[63:0];
            BK_RT:  p_reg <= p_reg + prod_reg[63:0];
            BK_SUB: p_reg <= p_reg - prod_reg[63:0];
            BK_ANGLE:
            begin
                quad_reg <= quad;
                cz_reg   <= 34'($signed(resid));
                cx_reg   <= CORDIC_START;
                cy_reg   <= '0;
                step_reg <= '0;
            end
            BK_ROT:
            begin
                if (!cz_reg[33])
                begin
                    cx_reg <= cx_reg - (cy_reg >>> step_reg);
                    cy_reg <= cy_reg + (cx_reg >>> step_reg);
                    cz_reg <= cz_reg - atan_turns(step_reg);
                end
                else
                begin
                    cx_reg <= cx_reg + (cy_reg >>> step_reg);
                    cy_reg <= cy_reg - (cx_reg >>> step_reg);
                    cz_reg <= cz_reg + atan_turns(step_reg);
                end
                step_reg <= step_reg + 5'd1;
            end
            BK_QUAD:
            begin
                case (quad_reg)
                    2'd0:
                    begin
                        c_reg <= cx_reg;
                        s_reg <= cy_reg;
                    end
                    2'd1:
                    begin
                        c_reg <= -cy_reg;
                        s_reg <= cx_reg;
                    end
                    2'd2:
                    begin
                        c_reg <= -cx_reg;
                        s_reg <= -cy_reg;
                    end
                    default:
                    begin
                        c_reg <= cy_reg;
                        s_reg <= -cx_reg;
                    end
                endcase
            end
            BK_AS: acc_e_reg <= acc_e_reg + prod_reg[63:0];
            BK_PS: ps_reg <= prod_reg[49:16];
            BK_SX: acc_x_reg <= acc_x_reg - 64'($signed(prod_reg[67:16]));
            BK_SY:
            begin
                acc_y_reg <= acc_y_reg - 64'($signed(prod_reg[67:16]));
                idx_reg   <= idx_reg + 1'b1;
            end
            BK_DONE:
            begin
                elev_reg <= sat32((acc_e_reg + 64'sd33554432) >>> 26);
                sx_reg   <= sat32((acc_x_reg + 64'sd32768) >>> 16);
                sy_reg   <= sat32((acc_y_reg + 64'sd32768) >>> 16);
            end
            default:
            begin
            end
        endcase
    end

    assign done      = done_reg;
    assign elevation = elev_reg;
    assign slope_x   = sx_reg;
    assign slope_y   = sy_reg;

endmodule

>>> sim/wave_elevation_superposition_tb.sv
// wave_elevation_superposition_tb: self-checking bench for the wave superposition block
// drives load and evaluate requests, predicts or presets each result, compares field by field
// depends on wes_pkg and wave_elevation_superposition
`timescale 1ns / 1ps

module wave_elevation_superposition_tb;
    import wes_pkg::*;

    localparam int N_ENTRIES = 64;
    localparam longint CYCLE_LIMIT = 20000000;
    localparam int ITEMS_PER_PHASE = 170;

    // arctangent of 2^-k in turns, 2^32 per turn
    localparam longint ATAN_TURNS [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304,
        652, 326, 163, 81
    };

    typedef struct {
        logic [31:0] elev;
        logic [31:0] sx;
        logic [31:0] sy;
    } surface_t;

    typedef struct {
        logic        sync;
        logic [6:0]  count;
        item_t       it;
        logic        typed;
        surface_t    res;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cmd;
    logic [5:0]  entry_index;
    logic [15:0] amplitude;
    logic [31:0] wavenumber_x;
    logic [31:0] wavenumber_y;
    logic [31:0] angular_rate;
    logic [15:0] phase_offset;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] query_time;
    logic [6:0]  term_limit;
    logic        done;
    logic [31:0] elevation;
    logic [31:0] slope_x;
    logic [31:0] slope_y;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor copy of the component table and the count register
    logic [15:0] amp_tab [N_ENTRIES];
    logic [31:0] kx_tab [N_ENTRIES];
    logic [31:0] ky_tab [N_ENTRIES];
    logic [31:0] rate_tab [N_ENTRIES];
    logic [15:0] phase_tab [N_ENTRIES];
    logic [6:0]  count_reg;

    surface_t    pending_surface [$];
    int          mismatches;
    longint      cycles;
    int          idle_pct;

    wave_elevation_superposition dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .entry_index(entry_index), .amplitude(amplitude),
        .wavenumber_x(wavenumber_x), .wavenumber_y(wavenumber_y),
        .angular_rate(angular_rate), .phase_offset(phase_offset),
        .pos_x(pos_x), .pos_y(pos_y), .query_time(query_time),
        .term_limit(term_limit), .done(done), .elevation(elevation),
        .slope_x(slope_x), .slope_y(slope_y), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    // clock
    always #10 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("wave_elevation_superposition_tb: done, errors");
            $finish;
        end
    end

    function automatic logic [31:0] clip32(input longint v);
        logic [31:0] r;
        if (v > 64'sh7FFF_FFFF)
            r = 32'h7FFF_FFFF;
        else if (v < -64'sh8000_0000)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // quadrant fold, then cordic rotation of the residual angle
    function automatic void rotate_angle(input logic [31:0] ang, output longint c,
                                         output longint s);
        logic [31:0] shifted;
        logic [1:0]  quad;
        logic [31:0] resid;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        shifted = ang + 32'h2000_0000;
        quad = shifted[31:30];
        resid = ang - {quad, 30'b0};
        z = longint'($signed(resid));
        x = longint'(CORDIC_START);
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TURNS[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TURNS[i];
            end
        end
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    // elevation and slopes summed over the used components
    function automatic surface_t wave_surface(input item_t it);
        surface_t    r;
        int          cnt;
        int          n;
        longint      px;
        longint      py;
        longint      kx;
        longint      ky;
        longint      a;
        longint      c;
        longint      s;
        longint      ps;
        longint      acc_e;
        longint      acc_x;
        longint      acc_y;
        logic [63:0] sum;
        logic [31:0] ang;
        px = longint'($signed(it.pos_x));
        py = longint'($signed(it.pos_y));
        cnt = (count_reg > N_ENTRIES) ? N_ENTRIES : int'(count_reg);
        n = (it.term_limit == 0 || it.term_limit >= cnt) ? cnt : int'(it.term_limit);
        acc_e = 0;
        acc_x = 0;
        acc_y = 0;
        for (int i = 0; i < n; i++)
        begin
            kx = longint'($signed(kx_tab[i]));
            ky = longint'($signed(ky_tab[i]));
            a = longint'({48'b0, amp_tab[i]});
            sum = 64'(kx * px) + 64'(ky * py)
                - ({32'b0, rate_tab[i]} * {32'b0, it.query_time});
            ang = sum[39:8] + {phase_tab[i], 16'b0};
            rotate_angle(ang, c, s);
            acc_e = acc_e + a * c;
            ps = (a * s) >>> 16;
            acc_x = acc_x - ((((ps * kx) >>> 30) * longint'(TWO_PI_Q28)) >>> 16);
            acc_y = acc_y - ((((ps * ky) >>> 30) * longint'(TWO_PI_Q28)) >>> 16);
        end
        r.elev = clip32((acc_e + (64'sd1 <<< 25)) >>> 26);
        r.sx = clip32((acc_x + (64'sd1 <<< 15)) >>> 16);
        r.sy = clip32((acc_y + (64'sd1 <<< 15)) >>> 16);
        return r;
    endfunction

    function automatic item_t load_req(input logic [5:0] idx, input logic [15:0] amp,
                                       input logic [31:0] kx, input logic [31:0] ky,
                                       input logic [31:0] rate, input logic [15:0] ph);
        item_t it;
        it = '0;
        it.cmd = CMD_LOAD;
        it.entry_index = idx;
        it.amplitude = amp;
        it.wavenumber_x = kx;
        it.wavenumber_y = ky;
        it.angular_rate = rate;
        it.phase_offset = ph;
        it.pos_x = $urandom;
        it.pos_y = $urandom;
        it.query_time = $urandom;
        it.term_limit = 7'($urandom_range(0, 64));
        return it;
    endfunction

    function automatic item_t eval_req(input logic [31:0] x, input logic [31:0] y,
                                       input logic [31:0] t, input logic [6:0] lim);
        item_t it;
        it = '0;
        it.cmd = CMD_EVAL;
        it.entry_index = 6'($urandom);
        it.amplitude = 16'($urandom);
        it.wavenumber_x = $urandom;
        it.wavenumber_y = $urandom;
        it.angular_rate = $urandom;
        it.phase_offset = 16'($urandom);
        it.pos_x = x;
        it.pos_y = y;
        it.query_time = t;
        it.term_limit = lim;
        return it;
    endfunction

    function automatic item_t random_load(input logic [5:0] idx);
        logic [15:0] amp;
        case ($urandom_range(0, 3))
            0: amp = 16'hFFFF;
            1: amp = 16'h0000;
            default: amp = 16'($urandom);
        endcase
        return load_req(idx, amp, $urandom, $urandom, $urandom, 16'($urandom));
    endfunction

    function automatic item_t random_eval();
        logic [6:0] lim;
        int         pick;
        pick = $urandom_range(0, 9);
        if (pick < 8)
            lim = 7'($urandom_range(1, 6));
        else if (pick == 8)
            lim = 0;
        else
            lim = 7'($urandom_range(0, 64));
        return eval_req($urandom, $urandom, $urandom, lim);
    endfunction

    // hold one request on the ports until it is taken
    task automatic send_request(input item_t it, input logic typed, input surface_t res);
        cmd <= it.cmd;
        entry_index <= it.entry_index;
        amplitude <= it.amplitude;
        wavenumber_x <= it.wavenumber_x;
        wavenumber_y <= it.wavenumber_y;
        angular_rate <= it.angular_rate;
        phase_offset <= it.phase_offset;
        pos_x <= it.pos_x;
        pos_y <= it.pos_y;
        query_time <= it.query_time;
        term_limit <= it.term_limit;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        if (it.cmd == CMD_LOAD)
        begin
            amp_tab[it.entry_index] = it.amplitude;
            kx_tab[it.entry_index] = it.wavenumber_x;
            ky_tab[it.entry_index] = it.wavenumber_y;
            rate_tab[it.entry_index] = it.angular_rate;
            phase_tab[it.entry_index] = it.phase_offset;
        end
        else if (typed)
            pending_surface.insert(pending_surface.size(), res);
        else
            pending_surface.insert(pending_surface.size(), wave_surface(it));
    endtask

    task automatic sender_gap();
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // let the block drain, then write the count register over apb
    task automatic set_count(input logic [6:0] value);
        start <= 1'b0;
        while (pending_surface.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(REG_COUNT) << 2;
        pwdata <= {25'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        count_reg = value;
        @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        surface_t want;
        if (rst_n && done)
        begin
            if (pending_surface.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: elev %h sx %h sy %h",
                             elevation, slope_x, slope_y);
            end
            else
            begin
                want = pending_surface.pop_front();
                if (want.elev !== elevation || want.sx !== slope_x || want.sy !== slope_y)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h %h %h got %h %h %h",
                                 want.elev, want.sx, want.sy,
                                 elevation, slope_x, slope_y);
                end
            end
        end
    end

    initial
    begin
        dir_row_t    rows [18];
        surface_t    zero_res;
        logic [6:0]  phase_counts [7];
        int          total;
        int          wait_cycles;

        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = CMD_LOAD;
        entry_index = '0;
        amplitude = '0;
        wavenumber_x = '0;
        wavenumber_y = '0;
        angular_rate = '0;
        phase_offset = '0;
        pos_x = '0;
        pos_y = '0;
        query_time = '0;
        term_limit = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        cycles = 0;
        idle_pct = 0;
        count_reg = '0;
        zero_res = '{32'h0, 32'h0, 32'h0};
        for (int i = 0; i < N_ENTRIES; i++)
        begin
            amp_tab[i] = '0;
            kx_tab[i] = '0;
            ky_tab[i] = '0;
            rate_tab[i] = '0;
            phase_tab[i] = '0;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extreme entries, quadrant phases, term limits
        rows[0] = '{0, 0, eval_req(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 64),
                    1, zero_res};
        rows[1] = '{0, 0, load_req(0, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                   32'hFFFF_FFFF, 16'hFFFF), 0, zero_res};
        rows[2] = '{0, 0, load_req(1, 16'h0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                   32'h0, 16'h0), 0, zero_res};
        rows[3] = '{0, 0, load_req(2, 16'hFFFF, 32'h0, 32'h0, 32'h0, 16'h0000),
                    0, zero_res};
        rows[4] = '{0, 0, load_req(3, 16'hFFFF, 32'h0100_0000, 32'h0, 32'h0,
                                   16'h4000), 0, zero_res};
        rows[5] = '{0, 0, load_req(4, 16'hFFFF, 32'h0, 32'hFF00_0000, 32'h0100_0000,
                                   16'h8000), 0, zero_res};
        rows[6] = '{0, 0, load_req(5, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                   32'h0, 16'hC000), 0, zero_res};
        rows[7] = '{0, 0, load_req(63, 16'h1234, 32'h5555_5555, 32'hAAAA_AAAA,
                                   32'h0F0F_0F0F, 16'h5A5A), 0, zero_res};
        rows[8] = '{0, 0, eval_req(32'h0001_0000, 32'h0, 32'h0, 0), 1, zero_res};
        rows[9] = '{1, 6, eval_req(32'h0, 32'h0, 32'h0, 0), 0, zero_res};
        rows[10] = '{0, 0, eval_req(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1),
                     0, zero_res};
        rows[11] = '{0, 0, eval_req(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 6),
                     0, zero_res};
        rows[12] = '{0, 0, eval_req(32'h0000_4000, 32'hFFFF_C000, 32'h0001_0000, 64),
                     0, zero_res};
        rows[13] = '{0, 0, eval_req(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 3),
                     0, zero_res};
        rows[14] = '{0, 0, eval_req(32'h0003_0000, 32'h0, 32'h0000_8000, 5),
                     0, zero_res};
        rows[15] = '{0, 0, load_req(2, 16'h0000, 32'h0, 32'h0, 32'h0, 16'h0),
                     0, zero_res};
        rows[16] = '{0, 0, eval_req(32'h0001_0000, 32'h0002_0000, 32'h0, 0),
                     0, zero_res};
        rows[17] = '{1, 0, eval_req(32'h1234_5678, 32'h8765_4321, 32'h1, 6),
                     1, zero_res};
        foreach (rows[i])
        begin
            if (rows[i].sync)
                set_count(rows[i].count);
            send_request(rows[i].it, rows[i].typed, rows[i].res);
        end

        // fill the whole table so that any count is safe to evaluate
        idle_pct = 6;
        for (int i = 0; i < N_ENTRIES; i++)
        begin
            send_request(random_load(6'(i)), 0, zero_res);
            if ($urandom_range(0, 3) == 0)
                send_request(random_eval(), 0, zero_res);
            sender_gap();
        end

        // random phases across count settings, extremes included
        phase_counts = '{1, 64, 5, 127, 12, 100, 3};
        total = 0;
        foreach (phase_counts[p])
        begin
            set_count(phase_counts[p]);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (total < 400)
                    idle_pct = 6;
                else if (total < 800)
                    idle_pct = 83;
                else
                    idle_pct = 0;
                if ($urandom_range(0, 9) < 3)
                    send_request(random_load(6'($urandom_range(0, 63))), 0, zero_res);
                else
                    send_request(random_eval(), 0, zero_res);
                total++;
                if (idle_pct > 0)
                    sender_gap();
            end
        end
        start <= 1'b0;

        // drain
        wait_cycles = 0;
        while (pending_surface.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (100) @(posedge clk);
        if (mismatches == 0 && pending_surface.size() == 0)
            $display("wave_elevation_superposition_tb: done, clean");
        else
            $display("wave_elevation_superposition_tb: done, errors");
        $finish;
    end

endmodule
